### src/qstd_pkg.sv
// ----------------------------------------------------------------------------
// qstd_pkg
// Types, character codes and hex digit decode shared by the query string
// tokenize and decode unit.
// ----------------------------------------------------------------------------
package qstd_pkg;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_EQUALS  = 8'h3D;
  localparam logic [7:0] CH_AMP     = 8'h26;
  localparam logic [7:0] CH_SEMI    = 8'h3B;

  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_KEY   = 2'd1,
    PH_VALUE = 2'd2,
    PH_SKIP  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ESC_NONE = 2'd0,
    ESC_PCT  = 2'd1,
    ESC_HIGH = 2'd2
  } esc_t;

  typedef struct packed {
    logic [7:0] data;
    logic       bvalid;
    logic       inval;
    logic       eop;
  } qstd_res_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] nib;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] b);
    hex_t h;
    h.ok  = 1'b1;
    h.nib = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      h.nib = 4'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      h.nib = 4'(b - 8'h57);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      h.nib = 4'(b - 8'h37);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

### src/query_string_tokenize_decode_unit.sv
// ----------------------------------------------------------------------------
// query_string_tokenize_decode_unit
// Splits a raw URL query byte stream into key/value pairs and percent-decodes
// the bytes. Throughput: one byte per cycle unless out_tready stalls; the
// input register feeds the decode step, the result register parts the output
// side, and a byte's result reaches out_* through both. Synchronous active-low
// reset empties both registers and returns the tokenizer to pair start.
// ----------------------------------------------------------------------------
module query_string_tokenize_decode_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,   // end_of_query
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic [1:0] out_tuser,  // [0] byte_valid, [1] in_value
  output logic       out_tlast   // end_of_pair
);
  import qstd_pkg::*;

  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       in_eoq_r;
  logic       out_ready;
  logic       advance;
  logic       res_vld;
  qstd_res_t  res;

  assign advance   = in_vld_r && out_ready;
  assign in_tready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
      in_eoq_r  <= in_tlast;
    end
  end

  qstd_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .byte_in (in_byte_r),
    .eoq     (in_eoq_r),
    .res_vld (res_vld),
    .res     (res)
  );

  qstd_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (advance && res_vld),
    .res        (res),
    .ready      (out_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  a_stall_holds_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !out_ready |=> in_vld_r && $stable(in_byte_r) && $stable(in_eoq_r))
    else $error("pending input item lost during output stall");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !in_vld_r |-> in_tready)
    else $error("input refused while input register empty");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    advance && res_vld |=> out_tvalid)
    else $error("decoded result not presented");

endmodule

### src/qstd_core.sv
// ----------------------------------------------------------------------------
// qstd_core
// Tokenizer state and one-byte decode step; state advances per transaction.
// ----------------------------------------------------------------------------
module qstd_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                advance,
  input  logic [7:0]          byte_in,
  input  logic                eoq,
  output logic                res_vld,
  output qstd_pkg::qstd_res_t res
);
  import qstd_pkg::*;

  phase_t     phase_r, phase_nxt;
  esc_t       esc_r, esc_nxt;
  logic [3:0] hn_r, hn_nxt;
  hex_t       h;
  logic       is_sep;
  logic [7:0] lit;

  assign h      = hex_decode(byte_in);
  assign is_sep = eoq || byte_in == CH_AMP || byte_in == CH_SEMI;
  assign lit    = (byte_in == CH_PLUS) ? CH_SPACE : byte_in;

  always_comb begin
    phase_nxt = phase_r;
    esc_nxt   = esc_r;
    hn_nxt    = hn_r;
    res_vld   = 1'b0;
    res       = '0;
    if (is_sep) begin
      if (phase_r == PH_KEY || phase_r == PH_VALUE) begin
        res_vld    = 1'b1;
        res.eop    = 1'b1;
        res.inval  = (phase_r == PH_VALUE);
        res.bvalid = (esc_r == ESC_HIGH);
        res.data   = (esc_r == ESC_HIGH) ? {hn_r, 4'd0} : 8'd0;
      end
      phase_nxt = PH_START;
      esc_nxt   = ESC_NONE;
      hn_nxt    = 4'd0;
    end else if (phase_r == PH_SKIP) begin
      phase_nxt = PH_SKIP;
    end else if (phase_r == PH_START && byte_in == CH_EQUALS) begin
      phase_nxt = PH_SKIP;
    end else if (phase_r == PH_KEY && byte_in == CH_EQUALS) begin
      if (esc_r == ESC_HIGH) begin
        res_vld    = 1'b1;
        res.bvalid = 1'b1;
        res.data   = {hn_r, 4'd0};
      end
      phase_nxt = PH_VALUE;
      esc_nxt   = ESC_NONE;
      hn_nxt    = 4'd0;
    end else begin
      if (phase_r == PH_START) begin
        phase_nxt = PH_KEY;
      end
      res.inval = (phase_r == PH_VALUE);
      unique case (esc_r)
        ESC_NONE: begin
          if (byte_in == CH_PERCENT) begin
            esc_nxt = ESC_PCT;
          end else begin
            res_vld    = 1'b1;
            res.bvalid = 1'b1;
            res.data   = lit;
          end
        end
        ESC_PCT: begin
          if (h.ok) begin
            hn_nxt  = h.nib;
            esc_nxt = ESC_HIGH;
          end else begin
            esc_nxt    = ESC_NONE;
            res_vld    = 1'b1;
            res.bvalid = 1'b1;
            res.data   = lit;
          end
        end
        ESC_HIGH: begin
          esc_nxt    = ESC_NONE;
          hn_nxt     = 4'd0;
          res_vld    = 1'b1;
          res.bvalid = 1'b1;
          res.data   = {hn_r, h.ok ? h.nib : 4'd0};
        end
        default: begin
          esc_nxt = ESC_NONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      esc_r   <= ESC_NONE;
      hn_r    <= 4'd0;
    end else if (advance) begin
      phase_r <= phase_nxt;
      esc_r   <= esc_nxt;
      hn_r    <= hn_nxt;
    end
  end

  a_close_resets: assert property (@(posedge clk) disable iff (!rst_n)
    advance && res_vld && res.eop |=> phase_r == PH_START && esc_r == ESC_NONE)
    else $error("pair close did not return to pair start");

  a_esc_in_field: assert property (@(posedge clk) disable iff (!rst_n)
    esc_r != ESC_NONE |-> (phase_r == PH_KEY || phase_r == PH_VALUE))
    else $error("escape pending outside key or value");

  a_skip_silent: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_SKIP |-> !res_vld)
    else $error("result produced while skipping dropped pair");

endmodule

### src/qstd_out_reg.sv
// ----------------------------------------------------------------------------
// qstd_out_reg
// Result register toward the output stream; loads while empty or draining.
// ----------------------------------------------------------------------------
module qstd_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  qstd_pkg::qstd_res_t res,
  output logic                ready,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [7:0]          out_tdata,  // [7:0] out_byte
  output logic [1:0]          out_tuser,  // [0] byte_valid, [1] in_value
  output logic                out_tlast   // end_of_pair
);
  import qstd_pkg::*;

  logic      vld_r;
  qstd_res_t res_r;

  assign ready = !vld_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ready) begin
      vld_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && load) begin
      res_r <= res;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = res_r.data;
  assign out_tuser  = {res_r.inval, res_r.bvalid};
  assign out_tlast  = res_r.eop;

  a_empty_is_close: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tlast && out_tdata == 8'd0)
    else $error("result without byte is not a clean pair close");

  a_load_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
    ready && load |=> out_tvalid)
    else $error("loaded result not presented");

endmodule

### test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for query_string_tokenize_decode_unit. Drives raw query
// bytes on the input stream and keeps a transaction-level copy of the
// tokenizer and percent decoder. Each decoded result is checked against the
// oldest expected one. Stimulus covers directed corner cases, back-to-back
// traffic, randomly built key/value pairs, raw noise and random stalls on
// both sides.
// ----------------------------------------------------------------------------
module tb_top;
  import qstd_pkg::*;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;
  logic       in_tlast;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic [1:0] out_tuser;
  logic       out_tlast;

  int in_idle_pct  = 35;
  int out_idle_pct = 35;
  int items_sent   = 0;
  int results_seen = 0;
  int pairs_closed = 0;
  int mismatches   = 0;

  phase_t     tok_phase = PH_START;
  esc_t       esc_state = ESC_NONE;
  logic [3:0] hi_nib    = 4'd0;
  qstd_res_t  decoded_q[$];

  query_string_tokenize_decode_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= out_idle_pct);
  end

  function automatic logic [4:0] nibble_of(input logic [7:0] b);
    if (b inside {[8'h30:8'h39]}) return {1'b0, b[3:0]};
    if (b inside {[8'h61:8'h66], [8'h41:8'h46]}) return {1'b0, 4'(b[3:0] + 4'd9)};
    return 5'h10;
  endfunction

  task automatic decode_byte(input logic [7:0] b, input logic eoq);
    qstd_res_t  r;
    logic [4:0] h;
    logic [7:0] lit;
    r   = '0;
    h   = nibble_of(b);
    lit = (b == CH_PLUS) ? CH_SPACE : b;
    if (eoq || b == CH_AMP || b == CH_SEMI) begin
      if (tok_phase == PH_KEY || tok_phase == PH_VALUE) begin
        r.eop   = 1'b1;
        r.inval = (tok_phase == PH_VALUE);
        if (esc_state == ESC_HIGH) begin
          r.bvalid = 1'b1;
          r.data   = {hi_nib, 4'h0};
        end
        decoded_q.push_back(r);
      end
      tok_phase = PH_START;
      esc_state = ESC_NONE;
      hi_nib    = 4'd0;
    end else if (tok_phase == PH_SKIP) begin
      return;
    end else if (tok_phase == PH_START && b == CH_EQUALS) begin
      tok_phase = PH_SKIP;
    end else if (tok_phase == PH_KEY && b == CH_EQUALS) begin
      if (esc_state == ESC_HIGH) begin
        r.bvalid = 1'b1;
        r.data   = {hi_nib, 4'h0};
        decoded_q.push_back(r);
      end
      tok_phase = PH_VALUE;
      esc_state = ESC_NONE;
      hi_nib    = 4'd0;
    end else begin
      if (tok_phase == PH_START) tok_phase = PH_KEY;
      r.inval  = (tok_phase == PH_VALUE);
      r.bvalid = 1'b1;
      case (esc_state)
        ESC_NONE: begin
          if (b == CH_PERCENT) begin
            esc_state = ESC_PCT;
          end else begin
            r.data = lit;
            decoded_q.push_back(r);
          end
        end
        ESC_PCT: begin
          if (!h[4]) begin
            hi_nib    = h[3:0];
            esc_state = ESC_HIGH;
          end else begin
            esc_state = ESC_NONE;
            r.data    = lit;
            decoded_q.push_back(r);
          end
        end
        default: begin
          r.data    = {hi_nib, h[4] ? 4'h0 : h[3:0]};
          esc_state = ESC_NONE;
          hi_nib    = 4'd0;
          decoded_q.push_back(r);
        end
      endcase
    end
  endtask

  always @(posedge clk) begin
    qstd_res_t e;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (out_tlast) pairs_closed++;
      if (decoded_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result: data=%02h bv=%0d val=%0d eop=%0d",
                   out_tdata, out_tuser[0], out_tuser[1], out_tlast);
        end
      end else begin
        e = decoded_q.pop_front();
        if (out_tdata !== e.data || out_tuser[0] !== e.bvalid ||
            out_tuser[1] !== e.inval || out_tlast !== e.eop) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result %0d: exp data=%02h bv=%0d val=%0d eop=%0d, got data=%02h bv=%0d val=%0d eop=%0d",
                     results_seen, e.data, e.bvalid, e.inval, e.eop,
                     out_tdata, out_tuser[0], out_tuser[1], out_tlast);
          end
        end
      end
    end
  end

  task automatic send_item(input logic [7:0] b, input logic eoq);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= eoq;
    do @(posedge clk); while (!in_tready);
    decode_byte(b, eoq);
    items_sent++;
  endtask

  task automatic send_end();
    send_item(8'($urandom_range(255)), 1'b1);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  // hold the input idle until every pending transaction has drained
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [7:0] hex_char();
    int v;
    v = $urandom_range(15);
    if (v < 10) return 8'(8'h30 + v);
    return 8'(($urandom_range(1) ? 8'h41 : 8'h61) + v - 10);
  endfunction

  task automatic send_field_char();
    case ($urandom_range(9))
      0, 1, 2: send_item(8'(8'h61 + $urandom_range(25)), 1'b0);
      3:       send_item(8'(8'h30 + $urandom_range(9)), 1'b0);
      4:       send_item(CH_PLUS, 1'b0);
      5, 6: begin
        send_item(CH_PERCENT, 1'b0);
        send_item(hex_char(), 1'b0);
        send_item(hex_char(), 1'b0);
      end
      7: begin
        send_item(CH_PERCENT, 1'b0);
        send_item(8'($urandom_range(255)), 1'b0);
      end
      8: begin
        send_item(CH_PERCENT, 1'b0);
        send_item(hex_char(), 1'b0);
        send_item(8'($urandom_range(255)), 1'b0);
      end
      default: send_item(8'($urandom_range(255)), 1'b0);
    endcase
  endtask

  task automatic send_pair();
    int key_len;
    int val_len;
    key_len = $urandom_range(4);
    val_len = $urandom_range(5);
    repeat (key_len) send_field_char();
    if (key_len == 0 || $urandom_range(3) != 0) begin
      send_item(CH_EQUALS, 1'b0);
      repeat (val_len) send_field_char();
    end
    case ($urandom_range(2))
      0:       send_item(CH_AMP, 1'b0);
      1:       send_item(CH_SEMI, 1'b0);
      default: send_end();
    endcase
  endtask

  task automatic test_directed();
    send_text("a%=%6a%7");
    send_end();
    send_text("=x&");
    send_text(";%z%+%%%4z%");
    send_end();
    send_item(8'hFF, 1'b0);
    send_text("%B=");
    send_item(8'h00, 1'b0);
    send_text("=&");
    wait_drained();
  endtask

  task automatic test_back_to_back();
    int stop_at;
    stop_at      = items_sent + 100;
    in_idle_pct  = 0;
    out_idle_pct = 0;
    while (items_sent < stop_at) send_pair();
    in_idle_pct  = 35;
    out_idle_pct = 35;
  endtask

  task automatic test_random_pairs();
    int stop_at;
    int drain_at;
    stop_at  = items_sent + 320;
    drain_at = items_sent + 60;
    while (items_sent < stop_at) begin
      send_pair();
      if (items_sent >= drain_at) begin
        wait_drained();
        drain_at = items_sent + 60 + $urandom_range(40);
      end
    end
  endtask

  task automatic test_noise();
    repeat (60) send_item(8'($urandom_range(255)), $urandom_range(7) == 0);
    send_end();
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= 8'h00;
    in_tlast  <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_back_to_back();
    test_random_pairs();
    test_noise();
    wait_drained();
    repeat (8) @(posedge clk);
    $display("sent %0d query bytes; checked %0d decoded results across %0d closed pairs",
             items_sent, results_seen, pairs_closed);
    $display("covered escapes, separators, empty keys, stalls and back-to-back traffic");
    if (mismatches == 0 && decoded_q.size() == 0) begin
      $display("query_string_tokenize_decode_unit: match");
    end else begin
      $display("query_string_tokenize_decode_unit: mismatch");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("query_string_tokenize_decode_unit: mismatch");
    $finish;
  end

endmodule
